// ----- rtl/dtmfq_pkg.sv -----
// Shared types, constants and helpers for the DTMF digit sequence qualifier.
// No dependencies; imported by the top level and by its port checker.
`default_nettype none

package dtmfq_pkg;

  // Sequence store depth; one slot is kept free, so at most SEQ_DEPTH-1 digits.
  localparam int unsigned SEQ_DEPTH   = 32;
  // Width of the saturating sample counters.
  localparam int unsigned COUNT_WIDTH = 24;
  // Width of the threshold registers.
  localparam int unsigned THR_W       = 24;
  // Common width for counter against threshold compares.
  localparam int unsigned CMP_W       = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
  // Store index / fill count width.
  localparam int unsigned CNT_W       = (SEQ_DEPTH > 2) ? $clog2(SEQ_DEPTH) : 1;
  // Common width for read index against fill count.
  localparam int unsigned RD_W        = (CNT_W > 5) ? CNT_W : 5;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [7:0] SYM_NONE  = 8'h00;
  localparam logic [7:0] SYM_ALERT = 8'h21; // '!'
  localparam logic [7:0] SYM_LONGP = 8'h50; // 'P'

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TONE_EN   = 3'd0,
    REG_ALERT_EN  = 3'd1,
    REG_MIN_TONE  = 3'd2,
    REG_MIN_PAUSE = 3'd3,
    REG_LONG_TONE = 3'd4,
    REG_ALERT_SMP = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  detected_symbol;
    logic [15:0] frame_length;
    logic [4:0]  read_index;
  } dtmf_in_t;

  typedef struct packed {
    logic [4:0] sequence_length;
    logic [7:0] read_symbol;
    logic       symbol_accepted;
    logic       symbol_remapped;
    logic       sequence_ready;
  } dtmf_out_t;

  // Long-press letter of a keypad symbol; symbols without one map to themselves.
  function automatic logic [7:0] long_form(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h31:   r = 8'h51; // 1 -> Q
      8'h32:   r = 8'h57; // 2 -> W
      8'h33:   r = 8'h45; // 3 -> E
      8'h34:   r = 8'h52; // 4 -> R
      8'h35:   r = 8'h54; // 5 -> T
      8'h36:   r = 8'h5A; // 6 -> Z
      8'h37:   r = 8'h55; // 7 -> U
      8'h38:   r = 8'h49; // 8 -> I
      8'h39:   r = 8'h4F; // 9 -> O
      8'h30:   r = 8'h50; // 0 -> P
      8'h23:   r = 8'h53; // # -> S
      8'h2A:   r = 8'h44; // * -> D
      8'h41:   r = 8'h46; // A -> F
      8'h42:   r = 8'h47; // B -> G
      8'h43:   r = 8'h48; // C -> H
      default: r = c;
    endcase
    return r;
  endfunction

  // Counter plus frame length, clamped at all ones.
  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                     input logic [15:0] b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + (COUNT_WIDTH+1)'(b);
    return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dtmf_digit_sequence_qualifier_top.sv -----
// Top level of the DTMF digit sequence qualifier.
// Depends on dtmfq_pkg (item structs, command codes, long-press table, saturating add).
`default_nettype none

// Qualifies per-frame DTMF detector output into a stored digit sequence.
// Each input item is one command: a detector frame (symbol, 0 for silence, and
// the frame length in samples), a read of one store entry, or a clear of the
// sequence. A symbol is stored once it has stayed stable for more than
// min_tone_samples and, if digits are already stored, after a silent gap of at
// least min_pause_samples. A hold beyond long_tone_samples turns the last
// stored digit into its long-press letter (once per hold); a hold beyond
// alert_samples turns a leading 'P' into '!' when alert_enable is set. The
// store holds at most 31 digits; tone frames are ignored once it is full.
// Every item gives exactly one result item. Timing: one item is taken per
// clock; its result sits in the output register from the next cycle. The only
// stall back to the source is a result register that is still held by
// out_stall, so in_stall never rises while the output side keeps up.
// Duration counters are 24 bits and saturate. Thresholds and enables are
// written through the cfg_ port and take effect from the next item; write
// them only while the block is idle. No clearing pass is needed after reset.
module dtmf_digit_sequence_qualifier_top (
  input  wire                         clk,
  input  wire                         rst_n,
  // input item channel
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire dtmfq_pkg::dtmf_in_t    in_data,
  // result item channel
  output logic                        out_valid,
  input  wire                         out_stall,
  output dtmfq_pkg::dtmf_out_t        out_data,
  // configuration writes
  input  wire                         cfg_we,
  input  wire [dtmfq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [dtmfq_pkg::THR_W-1:0]  cfg_wdata
);
  import dtmfq_pkg::*;

  // configuration
  logic             tone_en_r;
  logic             alert_en_r;
  logic [THR_W-1:0] min_tone_r;
  logic [THR_W-1:0] min_pause_r;
  logic [THR_W-1:0] long_tone_r;
  logic [THR_W-1:0] alert_smp_r;

  // qualifier state
  logic [COUNT_WIDTH-1:0] tone_dur_r,  tone_dur_nxt;
  logic [COUNT_WIDTH-1:0] pause_dur_r, pause_dur_nxt;
  logic [7:0]             prev_sym_r,  prev_sym_nxt;
  logic                   long_seen_r, long_seen_nxt;
  logic [CNT_W-1:0]       count_r,     count_nxt;
  // copy of the last stored digit, so the store has a single indexed read
  logic [7:0]             last_sym_r,  last_sym_nxt;

  // Sequence store. Entries at or above count_r are stale and never read:
  // reads are gated by the fill count and every slot is written on append.
  logic [7:0] store_r [SEQ_DEPTH];

  // output register
  logic      out_valid_r;
  dtmf_out_t out_data_r;
  dtmf_out_t res;

  logic             accept;
  logic [CNT_W-1:0] last_idx;
  logic [COUNT_WIDTH-1:0] tone_sum;
  logic [7:0]       sym;
  logic [7:0]       track_sym;
  logic [7:0]       last_val;
  logic [7:0]       long_val;
  logic             have_seq;
  logic             full;
  logic             do_alert;
  logic             do_long;
  // store write strobes: entry 0 to '!', last entry remap, append at count_r
  logic             st0_we;
  logic             stl_we;
  logic             sta_we;
  logic [RD_W-1:0]  rd_idx;
  logic             rd_hit;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sym      = in_data.detected_symbol;
  assign last_idx = count_r - CNT_W'(1);
  assign have_seq = (count_r != '0);
  assign full     = (count_r >= CNT_W'(SEQ_DEPTH - 1));
  assign tone_sum = sat_add(tone_dur_r, in_data.frame_length);
  assign rd_idx   = RD_W'(in_data.read_index);
  assign rd_hit   = (rd_idx < RD_W'(count_r));

  always_comb begin
    tone_dur_nxt  = tone_dur_r;
    pause_dur_nxt = pause_dur_r;
    prev_sym_nxt  = prev_sym_r;
    long_seen_nxt = long_seen_r;
    count_nxt     = count_r;
    last_sym_nxt  = last_sym_r;
    st0_we        = 1'b0;
    stl_we        = 1'b0;
    sta_we        = 1'b0;
    track_sym     = (prev_sym_r == SYM_NONE) ? sym : prev_sym_r;

    do_alert = alert_en_r && have_seq && (store_r[0] == SYM_LONGP) &&
               (CMP_W'(tone_sum) > CMP_W'(alert_smp_r));
    do_long  = (CMP_W'(tone_sum) > CMP_W'(long_tone_r)) && !long_seen_r;
    // last digit as it stands after a possible alert on the same entry
    last_val = (do_alert && (last_idx == '0)) ? SYM_ALERT : last_sym_r;
    long_val = long_form(last_val);

    res                 = '0;
    res.symbol_accepted = 1'b0;
    res.symbol_remapped = 1'b0;
    res.read_symbol     = SYM_NONE;

    case (cmd_e'(in_data.command))
      CMD_FRAME: begin
        if (tone_en_r) begin
          if (sym == SYM_NONE) begin
            // silence: drop tone tracking, grow the gap
            tone_dur_nxt  = '0;
            prev_sym_nxt  = SYM_NONE;
            pause_dur_nxt = sat_add(pause_dur_r, in_data.frame_length);
          end else if (!full) begin
            if (sym != track_sym) begin
              // symbol changed mid tone: restart
              tone_dur_nxt = '0;
              prev_sym_nxt = SYM_NONE;
            end else begin
              tone_dur_nxt = tone_sum;
              prev_sym_nxt = track_sym;
              if (do_alert) begin
                st0_we = 1'b1;
                res.symbol_remapped = 1'b1;
                if (last_idx == '0) begin
                  last_sym_nxt = SYM_ALERT;
                end
              end
              if (do_long) begin
                long_seen_nxt = 1'b1;
                if (have_seq && (long_val != last_val)) begin
                  stl_we = 1'b1;
                  last_sym_nxt = long_val;
                  res.symbol_remapped = 1'b1;
                end
              end
              if (have_seq && (CMP_W'(pause_dur_r) < CMP_W'(min_pause_r))) begin
                // gap too short for a further digit
                prev_sym_nxt = SYM_NONE;
              end else if (CMP_W'(tone_sum) > CMP_W'(min_tone_r)) begin
                sta_we        = 1'b1;
                long_seen_nxt = 1'b0;
                count_nxt     = count_r + CNT_W'(1);
                last_sym_nxt  = sym;
                tone_dur_nxt  = '0;
                prev_sym_nxt  = SYM_NONE;
                pause_dur_nxt = '0;
                res.symbol_accepted = 1'b1;
              end else begin
                prev_sym_nxt = sym;
              end
            end
          end
        end
      end
      CMD_READ: begin
        if (rd_hit) begin
          res.read_symbol = store_r[rd_idx[CNT_W-1:0]];
        end
      end
      CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase

    res.sequence_length = 5'(count_nxt);
    res.sequence_ready  = (count_nxt != '0);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_en_r   <= 1'b0;
      alert_en_r  <= 1'b1;
      min_tone_r  <= THR_W'(615);
      min_pause_r <= THR_W'(4000);
      long_tone_r <= THR_W'(16000);
      alert_smp_r <= THR_W'(24000);
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_TONE_EN:   tone_en_r   <= cfg_wdata[0];
        REG_ALERT_EN:  alert_en_r  <= cfg_wdata[0];
        REG_MIN_TONE:  min_tone_r  <= cfg_wdata;
        REG_MIN_PAUSE: min_pause_r <= cfg_wdata;
        REG_LONG_TONE: long_tone_r <= cfg_wdata;
        REG_ALERT_SMP: alert_smp_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // qualifier state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_dur_r  <= '0;
      pause_dur_r <= '0;
      prev_sym_r  <= SYM_NONE;
      long_seen_r <= 1'b0;
      count_r     <= '0;
      last_sym_r  <= SYM_NONE;
    end else if (accept) begin
      tone_dur_r  <= tone_dur_nxt;
      pause_dur_r <= pause_dur_nxt;
      prev_sym_r  <= prev_sym_nxt;
      long_seen_r <= long_seen_nxt;
      count_r     <= count_nxt;
      last_sym_r  <= last_sym_nxt;
    end
  end

  // store writes; append and remap never hit the same entry
  always_ff @(posedge clk) begin
    for (int i = 0; i < SEQ_DEPTH; i++) begin
      if (accept) begin
        if (sta_we && (count_r == CNT_W'(i))) begin
          store_r[i] <= sym;
        end else if (stl_we && (last_idx == CNT_W'(i))) begin
          store_r[i] <= long_val;
        end else if (st0_we && (i == 0)) begin
          store_r[i] <= SYM_ALERT;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dtmfq_checker.sv -----
// Port-level checker for the DTMF digit sequence qualifier, bound to its top level.
// Depends on dtmfq_pkg (item structs) and dtmf_digit_sequence_qualifier_top.
`default_nettype none

module dtmfq_checker (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         in_stall,
  input wire                         out_valid,
  input wire                         out_stall,
  input wire dtmfq_pkg::dtmf_out_t   out_data
);
  import dtmfq_pkg::*;

  // a held result is kept unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");

  // the input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // ready flag follows the length
  a_ready_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.sequence_ready == (out_data.sequence_length != '0)))
    else $error("sequence_ready disagrees with sequence_length");

  // an appended digit leaves a non-empty sequence
  a_acc_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.symbol_accepted) |-> (out_data.sequence_length != '0))
    else $error("digit accepted into an empty sequence");

  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind dtmf_digit_sequence_qualifier_top dtmfq_checker u_dtmfq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
